// ===== sv/fmr_pkg.sv =====
package fmr_pkg;

    // Fixed field widths of the item channels
    localparam int SYM_W  = 13;
    localparam int POS_W  = 13;
    localparam int RANK_W = 14;
    localparam int STAT_W = 2;

    typedef logic [SYM_W-1:0]         sym_t;
    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic signed [RANK_W-1:0] rank_t;
    typedef logic [STAT_W-1:0]        status_t;

    // Item function codes
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // Result status codes
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_RANGE = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

    // Result selection codes
    typedef logic [2:0] res_t;
    localparam res_t RES_OK    = 3'd0;
    localparam res_t RES_FULL  = 3'd1;
    localparam res_t RES_NEG   = 3'd2;
    localparam res_t RES_RANGE = 3'd3;
    localparam res_t RES_TALLY = 3'd4;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic sym_wr;
        logic cnt_rd;
        logic cnt_inc;
        logic snap_start;
        logic snap_step;
        logic len_adv;
        logic div1;
        logic div2;
        logic div3;
        logic choose;
        logic cp_addr;
        logic cp_rd;
        logic scan_step;
        logic res_set;
        res_t res_sel;
        logic out_load;
    } fmr_cmd_t;

    typedef struct packed {
        logic item_query;
        logic pos_neg;
        logic pos_range;
        logic full;
        logic sym_nocount;
        logic phase_zero;
        logic clear_done;
        logic snap_done;
        logic scan_done;
        logic out_free;
    } fmr_stat_t;

endpackage

// ===== sv/fmr_ifs.sv =====
interface fmr_req_if;
    logic              valid;
    logic              ready;
    logic              func;
    fmr_pkg::sym_t     symbol;
    fmr_pkg::pos_t     position;

    modport source (output valid, output func, output symbol, output position, input ready);
    modport sink   (input valid, input func, input symbol, input position, output ready);
endinterface

interface fmr_rsp_if;
    logic              valid;
    logic              ready;
    fmr_pkg::rank_t    rank_count;
    fmr_pkg::status_t  status;

    modport source (output valid, output rank_count, output status, input ready);
    modport sink   (input valid, input rank_count, input status, output ready);
endinterface

// ===== sv/fmr_ctrl.sv =====
module fmr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  fmr_pkg::fmr_stat_t stat,
    output fmr_pkg::fmr_cmd_t  cmd
);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DECODE  = 4'd2;
    localparam logic [3:0] S_INC_RD  = 4'd3;
    localparam logic [3:0] S_INC_WR  = 4'd4;
    localparam logic [3:0] S_APP_END = 4'd5;
    localparam logic [3:0] S_SNAP    = 4'd6;
    localparam logic [3:0] S_DIV1    = 4'd7;
    localparam logic [3:0] S_DIV2    = 4'd8;
    localparam logic [3:0] S_DIV3    = 4'd9;
    localparam logic [3:0] S_CHOOSE  = 4'd10;
    localparam logic [3:0] S_CPADDR  = 4'd11;
    localparam logic [3:0] S_CPRD    = 4'd12;
    localparam logic [3:0] S_SCAN    = 4'd13;
    localparam logic [3:0] S_RESULT  = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        req_ready  = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!stat.item_query)
                begin
                    if (stat.full)
                    begin
                        cmd.res_set = 1'b1;
                        cmd.res_sel = fmr_pkg::RES_FULL;
                        state_next  = S_RESULT;
                    end
                    else
                    begin
                        cmd.sym_wr = 1'b1;
                        state_next = stat.sym_nocount ? S_APP_END : S_INC_RD;
                    end
                end
                else if (stat.pos_neg)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = fmr_pkg::RES_NEG;
                    state_next  = S_RESULT;
                end
                else if (stat.pos_range)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = fmr_pkg::RES_RANGE;
                    state_next  = S_RESULT;
                end
                else if (stat.sym_nocount)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = fmr_pkg::RES_OK;
                    state_next  = S_RESULT;
                end
                else
                begin
                    state_next = S_DIV1;
                end
            end
            S_INC_RD:
            begin
                cmd.cnt_rd = 1'b1;
                state_next = S_INC_WR;
            end
            S_INC_WR:
            begin
                cmd.cnt_inc = 1'b1;
                state_next  = S_APP_END;
            end
            S_APP_END:
            begin
                if (stat.phase_zero)
                begin
                    cmd.snap_start = 1'b1;
                    state_next     = S_SNAP;
                end
                else
                begin
                    cmd.len_adv = 1'b1;
                    cmd.res_set = 1'b1;
                    cmd.res_sel = fmr_pkg::RES_OK;
                    state_next  = S_RESULT;
                end
            end
            S_SNAP:
            begin
                if (stat.snap_done)
                begin
                    cmd.len_adv = 1'b1;
                    cmd.res_set = 1'b1;
                    cmd.res_sel = fmr_pkg::RES_OK;
                    state_next  = S_RESULT;
                end
                else
                begin
                    cmd.snap_step = 1'b1;
                end
            end
            S_DIV1:
            begin
                cmd.div1   = 1'b1;
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                cmd.div2   = 1'b1;
                state_next = S_DIV3;
            end
            S_DIV3:
            begin
                cmd.div3   = 1'b1;
                state_next = S_CHOOSE;
            end
            S_CHOOSE:
            begin
                cmd.choose = 1'b1;
                state_next = S_CPADDR;
            end
            S_CPADDR:
            begin
                cmd.cp_addr = 1'b1;
                state_next  = S_CPRD;
            end
            S_CPRD:
            begin
                cmd.cp_rd  = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = fmr_pkg::RES_TALLY;
                    state_next  = S_RESULT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/fmr_dp.sv =====
module fmr_dp #(
    parameter int MAX_LEN        = 4096,
    parameter int SAMPLE_SPACING = 64,
    parameter int SYMBOL_COUNT   = 4097
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_func,
    input  fmr_pkg::sym_t      req_symbol,
    input  fmr_pkg::pos_t      req_position,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output fmr_pkg::rank_t     rsp_rank_count,
    output fmr_pkg::status_t   rsp_status,
    input  fmr_pkg::fmr_cmd_t  cmd,
    output fmr_pkg::fmr_stat_t stat
);

    localparam int     LEN_W    = $clog2(MAX_LEN + 1);
    localparam int     IDX_W    = $clog2(MAX_LEN);
    localparam int     SP_W     = $clog2(SAMPLE_SPACING + 1);
    localparam int     ROWS     = MAX_LEN / SAMPLE_SPACING + 1;
    localparam int     ROW_W    = $clog2(ROWS + 1);
    localparam longint CP_DEPTH = longint'(ROWS) * longint'(SYMBOL_COUNT);
    localparam int     CP_AW    = $clog2(CP_DEPTH);
    localparam int     CNT_AW   = $clog2(SYMBOL_COUNT);
    localparam int     CTR_W    = $clog2(SYMBOL_COUNT + 1);
    localparam int     CMP_W    = (LEN_W > fmr_pkg::POS_W) ? LEN_W : fmr_pkg::POS_W;
    localparam int     NX_W     = ((LEN_W > SP_W) ? LEN_W : SP_W) + 1;
    localparam int     PR_W     = 2 * LEN_W + 1;
    localparam int     RECIP_I  = (1 << LEN_W) / SAMPLE_SPACING;
    localparam logic [LEN_W:0] RECIP = RECIP_I[LEN_W:0];

    // Stores
    logic [fmr_pkg::SYM_W-1:0] sym_mem [MAX_LEN];
    logic [LEN_W-1:0]          cnt_mem [SYMBOL_COUNT];
    logic [LEN_W-1:0]          cp_mem  [CP_DEPTH];

    // Item
    logic          item_func_reg;
    fmr_pkg::sym_t item_sym_reg;
    fmr_pkg::pos_t item_pos_reg;

    // Append bookkeeping
    logic [LEN_W-1:0]  len_reg;
    logic [SP_W-1:0]   phase_reg;
    logic [CP_AW-1:0]  base_reg;
    logic [CNT_AW-1:0] clr_idx_reg;

    logic [LEN_W-1:0]  cnt_rdata_reg;
    logic [CTR_W-1:0]  snap_ctr_reg;
    logic              snap_pend_reg;
    logic [CP_AW-1:0]  snap_waddr_reg;
    logic              snap_live;

    // Query datapath
    logic [LEN_W-1:0]  idx;
    logic [PR_W-1:0]   prod_reg;
    logic [LEN_W-1:0]  q_est;
    logic [LEN_W-1:0]  q_reg;
    logic [LEN_W-1:0]  qsp_reg;
    logic [LEN_W-1:0]  r_full;
    logic [LEN_W-1:0]  r_fix;
    logic              r_over;
    logic [SP_W-1:0]   r_reg;
    logic [LEN_W-1:0]  cp_lo;
    logic              later;
    logic [ROW_W-1:0]  row_reg;
    logic [CP_AW-1:0]  cp_addr_reg;
    logic [IDX_W-1:0]  scan_ptr_reg;
    logic [SP_W-1:0]   scan_left_reg;
    logic              scan_sub_reg;
    logic              scan_pend_reg;
    logic              scan_live;
    fmr_pkg::sym_t     sym_rdata_reg;
    logic [LEN_W-1:0]  tally_reg;

    // Results
    fmr_pkg::rank_t    res_rank_reg;
    fmr_pkg::status_t  res_status_reg;
    logic              out_valid_reg;
    fmr_pkg::rank_t    out_rank_reg;
    fmr_pkg::status_t  out_status_reg;

    // Counter store ports
    logic              cnt_we;
    logic [CNT_AW-1:0] cnt_waddr;
    logic [LEN_W-1:0]  cnt_wdata;
    logic              cnt_re;
    logic [CNT_AW-1:0] cnt_raddr;

    assign idx       = LEN_W'($unsigned(item_pos_reg));
    assign snap_live = snap_ctr_reg != CTR_W'(SYMBOL_COUNT);
    assign scan_live = scan_left_reg != '0;

    // Reciprocal quotient can come out one low; fix with a single subtract
    assign q_est  = prod_reg[2*LEN_W-1:LEN_W];
    assign r_full = idx - qsp_reg;
    assign r_over = r_full >= LEN_W'(SAMPLE_SPACING);
    assign r_fix  = r_full - LEN_W'(SAMPLE_SPACING);

    // Later checkpoint only when strictly closer and inside the loaded length
    assign cp_lo = idx - LEN_W'(r_reg);
    assign later = ({r_reg, 1'b0} > (SP_W+1)'(SAMPLE_SPACING))
                && ((NX_W'(cp_lo) + NX_W'(SAMPLE_SPACING)) < NX_W'(len_reg));

    always_comb
    begin
        cnt_we    = cmd.clear_step || cmd.cnt_inc;
        cnt_waddr = cmd.clear_step ? clr_idx_reg : item_sym_reg[CNT_AW-1:0];
        cnt_wdata = cmd.clear_step ? '0 : cnt_rdata_reg + LEN_W'(1);
        cnt_re    = cmd.cnt_rd || (cmd.snap_step && snap_live);
        cnt_raddr = cmd.snap_step ? snap_ctr_reg[CNT_AW-1:0] : item_sym_reg[CNT_AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rdata_reg <= cnt_mem[cnt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.snap_step && snap_pend_reg)
        begin
            cp_mem[snap_waddr_reg] <= cnt_rdata_reg;
        end
        if (cmd.cp_rd)
        begin
            tally_reg <= cp_mem[cp_addr_reg];
        end
        else if (cmd.scan_step && scan_pend_reg && (sym_rdata_reg == item_sym_reg))
        begin
            tally_reg <= scan_sub_reg ? tally_reg - LEN_W'(1) : tally_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sym_wr)
        begin
            sym_mem[len_reg[IDX_W-1:0]] <= item_sym_reg;
        end
        if (cmd.scan_step && scan_live)
        begin
            sym_rdata_reg <= sym_mem[scan_ptr_reg];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_func_reg <= req_func;
            item_sym_reg  <= req_symbol;
            item_pos_reg  <= req_position;
        end
        if (cmd.snap_start || (cmd.snap_step && snap_live))
        begin
            snap_waddr_reg <= base_reg + CP_AW'(snap_ctr_reg);
        end
        if (cmd.div1)
        begin
            prod_reg <= PR_W'(idx) * PR_W'(RECIP);
        end
        if (cmd.div2)
        begin
            q_reg   <= q_est;
            qsp_reg <= q_est * LEN_W'(SAMPLE_SPACING);
        end
        if (cmd.div3)
        begin
            q_reg <= r_over ? q_reg + LEN_W'(1) : q_reg;
            r_reg <= SP_W'(r_over ? r_fix : r_full);
        end
        if (cmd.choose)
        begin
            row_reg       <= later ? ROW_W'(q_reg) + ROW_W'(1) : ROW_W'(q_reg);
            scan_ptr_reg  <= later ? IDX_W'(idx) + IDX_W'(1) : IDX_W'(cp_lo) + IDX_W'(1);
            scan_left_reg <= later ? SP_W'(SAMPLE_SPACING) - r_reg : r_reg;
            scan_sub_reg  <= later;
        end
        else if (cmd.scan_step && scan_live)
        begin
            scan_ptr_reg  <= scan_ptr_reg + IDX_W'(1);
            scan_left_reg <= scan_left_reg - SP_W'(1);
        end
        if (cmd.cp_addr)
        begin
            cp_addr_reg <= CP_AW'(longint'(row_reg) * longint'(SYMBOL_COUNT)
                                  + longint'(item_sym_reg));
        end
        if (cmd.res_set)
        begin
            unique case (cmd.res_sel)
                fmr_pkg::RES_FULL:
                begin
                    res_rank_reg   <= '0;
                    res_status_reg <= fmr_pkg::STATUS_FULL;
                end
                fmr_pkg::RES_NEG:
                begin
                    res_rank_reg   <= '1;
                    res_status_reg <= fmr_pkg::STATUS_OK;
                end
                fmr_pkg::RES_RANGE:
                begin
                    res_rank_reg   <= '0;
                    res_status_reg <= fmr_pkg::STATUS_RANGE;
                end
                fmr_pkg::RES_TALLY:
                begin
                    res_rank_reg   <= $signed(fmr_pkg::RANK_W'(tally_reg));
                    res_status_reg <= fmr_pkg::STATUS_OK;
                end
                default:
                begin
                    res_rank_reg   <= '0;
                    res_status_reg <= fmr_pkg::STATUS_OK;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            out_rank_reg   <= res_rank_reg;
            out_status_reg <= res_status_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            phase_reg     <= '0;
            base_reg      <= '0;
            clr_idx_reg   <= '0;
            snap_ctr_reg  <= '0;
            snap_pend_reg <= 1'b0;
            scan_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_idx_reg <= clr_idx_reg + CNT_AW'(1);
            end
            if (cmd.len_adv)
            begin
                len_reg <= len_reg + LEN_W'(1);
                if (phase_reg == SP_W'(SAMPLE_SPACING - 1))
                begin
                    phase_reg <= '0;
                    base_reg  <= base_reg + CP_AW'(SYMBOL_COUNT);
                end
                else
                begin
                    phase_reg <= phase_reg + SP_W'(1);
                end
            end
            if (cmd.snap_start)
            begin
                snap_ctr_reg  <= '0;
                snap_pend_reg <= 1'b0;
            end
            else if (cmd.snap_step)
            begin
                snap_pend_reg <= snap_live;
                if (snap_live)
                begin
                    snap_ctr_reg <= snap_ctr_reg + CTR_W'(1);
                end
            end
            if (cmd.scan_step)
            begin
                scan_pend_reg <= scan_live;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat             = '0;
        stat.item_query  = item_func_reg == fmr_pkg::FUNC_QUERY;
        stat.pos_neg     = item_pos_reg[fmr_pkg::POS_W-1];
        stat.pos_range   = CMP_W'($unsigned(item_pos_reg)) >= CMP_W'(len_reg);
        stat.full        = len_reg == LEN_W'(MAX_LEN);
        stat.sym_nocount = item_sym_reg >= fmr_pkg::SYM_W'(SYMBOL_COUNT);
        stat.phase_zero  = phase_reg == '0;
        stat.clear_done  = clr_idx_reg == CNT_AW'(SYMBOL_COUNT - 1);
        stat.snap_done   = !snap_live && !snap_pend_reg;
        stat.scan_done   = !scan_live && !scan_pend_reg;
        stat.out_free    = !out_valid_reg || rsp_ready;
    end

    assign rsp_valid      = out_valid_reg;
    assign rsp_rank_count = out_rank_reg;
    assign rsp_status     = out_status_reg;

endmodule

// ===== sv/fm_index_sampled_rank.sv =====
// Sampled occurrence-rank store for an FM index.
// Channel req carries items (func, symbol, position): func append stores the
// next BWT symbol and counts it; func query asks how often symbol occurs in
// positions 0..position. Channel rsp returns one item (rank_count, status)
// per request, in order. Both channels use a valid/ready handshake.
// One item is worked at a time; req.ready is high only while idle.
// Query: decode, divide steps, checkpoint choice, address and read precede
// the scan; the result is then set and copied to the output register before
// the next request is taken. The scan covers at most SAMPLE_SPACING/2
// symbols when the later checkpoint is loaded, but up to SAMPLE_SPACING-1
// near the end of the loaded length, where only the earlier one exists;
// symbols are read one per cycle from the store's single read port.
// Append: the symbol write, then counter read and increment for a symbol that
// has a counter, precede the result; an append at a position that is a
// multiple of SAMPLE_SPACING also copies every symbol counter into a
// checkpoint row, one counter per cycle. Reset empties the store and starts
// a clearing pass over every counter; req.ready stays low meanwhile.
// A finished result sits in the rsp output register; while rsp.ready is low it
// holds, the next request is still taken, and that request's result waits.
module fm_index_sampled_rank #(
    parameter int MAX_LEN        = 4096,
    parameter int SAMPLE_SPACING = 64,
    parameter int SYMBOL_COUNT   = 4097
) (
    input logic       clk,
    input logic       rst_n,
    fmr_req_if.sink   req,
    fmr_rsp_if.source rsp
);

    fmr_pkg::fmr_cmd_t  cmd;
    fmr_pkg::fmr_stat_t stat;

    // Sequence each item
    fmr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold stores, counters and the output register
    fmr_dp #(
        .MAX_LEN        (MAX_LEN),
        .SAMPLE_SPACING (SAMPLE_SPACING),
        .SYMBOL_COUNT   (SYMBOL_COUNT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_func       (req.func),
        .req_symbol     (req.symbol),
        .req_position   (req.position),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .rsp_rank_count (rsp.rank_count),
        .rsp_status     (rsp.status),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

// ===== sv/fmr_chk.sv =====
module fmr_chk (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input fmr_pkg::rank_t   rsp_rank_count,
    input fmr_pkg::status_t rsp_status
);

    // Stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rank_count) && $stable(rsp_status))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == fmr_pkg::STATUS_OK || rsp_status == fmr_pkg::STATUS_RANGE
                       || rsp_status == fmr_pkg::STATUS_FULL))
        else $error("unknown status code");

    // Error results carry a zero rank
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != fmr_pkg::STATUS_OK |-> rsp_rank_count == '0)
        else $error("error result with nonzero rank");

    // One item in flight: ready drops right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second item taken while busy");

endmodule

bind fm_index_sampled_rank fmr_chk u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_rank_count (rsp.rank_count),
    .rsp_status     (rsp.status)
);
